// ----- rtl/core/tpa_pkg.sv -----
// tpa_pkg: shared constants, codes and types of the tagged pool allocator
// no dependencies; imported by tpa_store and tagged_pool_allocator_top
package tpa_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int PTR_W       = IDX_W + 1;
   localparam int TAG_W       = 16;
   localparam int CNT_W       = 6;
   localparam int MAX_GRANTS  = 32;

   localparam logic [PTR_W-1:0] PTR_EMPTY = PTR_W'(MAX_ENTRIES);
   localparam logic [TAG_W-1:0] NO_TAG    = 16'hFFFF;
   localparam logic [TAG_W-1:0] TAG_MAX   = 16'h7FFF;

   // slot states
   localparam logic [1:0] ST_ABSENT = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_BUSY   = 2'd2;

   // request actions
   localparam logic [1:0] ACT_GET     = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_DROP    = 2'd2;

   // response codes
   localparam logic [1:0] RSP_OK       = 2'd0;
   localparam logic [1:0] RSP_EXHAUST  = 2'd1;
   localparam logic [1:0] RSP_NOT_BUSY = 2'd2;

   // store operations
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_TAKE = 2'd1;
   localparam logic [1:0] OP_IDLE = 2'd2;
   localparam logic [1:0] OP_FREE = 2'd3;

   typedef struct packed {
      logic [1:0]       op;
      logic [IDX_W-1:0] idx;
      logic [PTR_W-1:0] prev;
      logic             unlink;
      logic             wr_tag;
      logic [TAG_W-1:0] tag;
      logic             clear_head;
   } store_cmd_type;

endpackage

// ----- rtl/core/tpa_store.sv -----
// tpa_store: slot state, tag and idle-list link arrays plus the idle list head
// depends on tpa_pkg; driven one command per cycle by the top-level sequencer
module tpa_store
   import tpa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  store_cmd_type       cmd,
   input  logic [IDX_W-1:0]    rd_idx,
   output logic [1:0]          rd_status,
   output logic [TAG_W-1:0]    rd_tag,
   output logic [PTR_W-1:0]    rd_link,
   output logic [PTR_W-1:0]    head
);

   logic [1:0]       status_ff [MAX_ENTRIES];
   logic [TAG_W-1:0] tag_ff    [MAX_ENTRIES];
   logic [PTR_W-1:0] link_ff   [MAX_ENTRIES];
   logic [PTR_W-1:0] head_ff;

   assign rd_status = status_ff[rd_idx];
   assign rd_tag    = tag_ff[rd_idx];
   assign rd_link   = link_ff[rd_idx];
   assign head      = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_ENTRIES; k++) begin
            status_ff[k] <= ST_ABSENT;
         end
         head_ff <= PTR_EMPTY;
      end else begin
         unique case (cmd.op)
            OP_TAKE: begin
               status_ff[cmd.idx] <= ST_BUSY;
               if (cmd.unlink) begin
                  if (cmd.prev[IDX_W]) begin
                     head_ff <= link_ff[cmd.idx];
                  end
               end
            end
            OP_IDLE: begin
               status_ff[cmd.idx] <= ST_IDLE;
               head_ff <= {1'b0, cmd.idx};
            end
            OP_FREE: begin
               if (status_ff[cmd.idx] == ST_IDLE) begin
                  status_ff[cmd.idx] <= ST_ABSENT;
               end
               if (cmd.clear_head) begin
                  head_ff <= PTR_EMPTY;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // tag and link payload carry no reset
   always_ff @(posedge clock) begin
      if ((cmd.op == OP_TAKE || cmd.op == OP_IDLE) && cmd.wr_tag) begin
         tag_ff[cmd.idx] <= cmd.tag;
      end
      if (cmd.op == OP_TAKE && cmd.unlink && !cmd.prev[IDX_W]) begin
         link_ff[cmd.prev[IDX_W-1:0]] <= link_ff[cmd.idx];
      end
      if (cmd.op == OP_IDLE) begin
         link_ff[cmd.idx] <= head_ff;
      end
   end

   // list head always names an idle slot
   a_head_idle: assert property (@(posedge clock) disable iff (reset)
      !head_ff[IDX_W] |-> status_ff[head_ff[IDX_W-1:0]] == ST_IDLE)
      else $error("idle head points at a slot that is not idle");

   a_idle_push: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_IDLE |=> head_ff == {1'b0, $past(cmd.idx)})
      else $error("idled slot did not become list head");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_TAKE |=> status_ff[$past(cmd.idx)] == ST_BUSY)
      else $error("taken slot not marked busy");

endmodule

// ----- rtl/core/tagged_pool_allocator_top.sv -----
// tagged_pool_allocator_top: request sequencer, grant list and response port
// depends on tpa_pkg and tpa_store
//
//   channel | ports                      | direction
//   req     | req_valid/req_ready + 4    | in
//   rsp     | rsp_valid/rsp_ready + 5    | out
//   csr     | csr_write_en/csr_write_data| in
//
// one transaction at a time through a single slot-store port and tag compare
// get: per handle, a tagged request walks the idle list for a matching tag (up to 32
// idle entries) and takes the list head on a miss or when untagged; with no idle slot
// it scans for an absent slot (up to 32) while below the limit, else rolls back grants;
// release idles one busy slot, drop frees every idle slot, then the response beats follow
// reset clears slot states, idle head, live count and sets the limit to 32
// req_ready is low from acceptance until the final response is taken
module tagged_pool_allocator_top
   import tpa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_action,
   input  logic [CNT_W-1:0]        req_count,
   input  logic signed [TAG_W-1:0] req_work_tag,
   input  logic [4:0]              req_handle,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [4:0]              rsp_granted_handle,
   output logic                    rsp_handle_valid,
   output logic                    rsp_last,
   output logic [CNT_W-1:0]        rsp_live_count,
   input  logic                    csr_write_en,
   input  logic [CNT_W-1:0]        csr_write_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TAKE = 3'd1;
   localparam logic [2:0] S_HEAD = 3'd2;
   localparam logic [2:0] S_WALK = 3'd3;
   localparam logic [2:0] S_SCAN = 3'd4;
   localparam logic [2:0] S_ROLL = 3'd5;
   localparam logic [2:0] S_DROP = 3'd6;
   localparam logic [2:0] S_RESP = 3'd7;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [TAG_W-1:0] start_ff, start_in;
   logic [TAG_W-1:0] tcur_ff, tcur_in;
   logic [PTR_W-1:0] cur_ff, cur_in;
   logic [PTR_W-1:0] prev_ff, prev_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] oidx_ff, oidx_in;
   logic             succ_ff, succ_in;
   logic [1:0]       status_ff, status_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic [CNT_W-1:0] limit_ff;
   logic [IDX_W-1:0] granted_ff [MAX_GRANTS];

   store_cmd_type    cmd;
   logic [IDX_W-1:0] rd_idx;
   logic [1:0]       rd_status;
   logic [TAG_W-1:0] rd_tag;
   logic [PTR_W-1:0] rd_link;
   logic [PTR_W-1:0] head;

   logic             grant;
   logic [IDX_W-1:0] grant_idx;
   logic [IDX_W-1:0] g_addr;
   logic [IDX_W-1:0] g_data;
   logic [TAG_W-1:0] req_tag;
   logic [TAG_W-1:0] tag_next;
   logic [TAG_W:0]   roll_sum;
   logic [TAG_W-1:0] roll_tag;

   tpa_store u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .rd_idx    (rd_idx),
      .rd_status (rd_status),
      .rd_tag    (rd_tag),
      .rd_link   (rd_link),
      .head      (head)
   );

   // any negative tag means no tag
   assign req_tag  = req_work_tag[TAG_W-1] ? NO_TAG : req_work_tag;
   assign tag_next = (tcur_ff == NO_TAG || tcur_ff == TAG_MAX) ? tcur_ff
                                                               : tcur_ff + 16'd1;
   assign g_addr   = (state_ff == S_ROLL) ? IDX_W'(i_ff - 6'd1) : oidx_ff;
   assign g_data   = granted_ff[g_addr];
   assign roll_sum = {1'b0, start_ff} + (TAG_W+1)'(i_ff - 6'd1);
   assign roll_tag = (roll_sum > {1'b0, TAG_MAX}) ? TAG_MAX : roll_sum[TAG_W-1:0];

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = (state_ff == S_RESP);
   assign rsp_status         = status_ff;
   assign rsp_handle_valid   = succ_ff;
   assign rsp_granted_handle = succ_ff ? g_data : '0;
   assign rsp_last           = !succ_ff || ({1'b0, oidx_ff} == cnt_ff - 6'd1);
   assign rsp_live_count     = live_ff;

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      cnt_in    = cnt_ff;
      start_in  = start_ff;
      tcur_in   = tcur_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      n_in      = n_ff;
      scan_in   = scan_ff;
      oidx_in   = oidx_ff;
      succ_in   = succ_ff;
      status_in = status_ff;
      live_in   = live_ff;
      cmd       = '0;
      cmd.op    = OP_NONE;
      cmd.prev  = PTR_EMPTY;
      rd_idx    = req_handle;
      grant     = 1'b0;
      grant_idx = head[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               succ_in   = 1'b0;
               status_in = RSP_OK;
               oidx_in   = '0;
               state_in  = S_RESP;
               unique case (req_action)
                  ACT_GET: begin
                     if (req_count > CNT_W'(MAX_GRANTS)) begin
                        status_in = RSP_EXHAUST;
                     end else if (req_count != '0) begin
                        i_in     = '0;
                        cnt_in   = req_count;
                        start_in = req_tag;
                        tcur_in  = req_tag;
                        state_in = S_TAKE;
                     end
                  end
                  ACT_RELEASE: begin
                     if (rd_status == ST_BUSY) begin
                        cmd.op     = OP_IDLE;
                        cmd.idx    = req_handle;
                        cmd.wr_tag = (req_tag != NO_TAG);
                        cmd.tag    = req_tag;
                     end else begin
                        status_in = RSP_NOT_BUSY;
                     end
                  end
                  ACT_DROP: begin
                     scan_in  = '0;
                     state_in = S_DROP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TAKE: begin
            if (!head[IDX_W]) begin
               if (tcur_ff != NO_TAG) begin
                  cur_in   = head;
                  prev_in  = PTR_EMPTY;
                  n_in     = '0;
                  state_in = S_WALK;
               end else begin
                  state_in = S_HEAD;
               end
            end else if (live_ff < limit_ff) begin
               scan_in  = '0;
               state_in = S_SCAN;
            end else begin
               state_in = S_ROLL;
            end
         end
         S_HEAD: begin
            cmd.op     = OP_TAKE;
            cmd.idx    = head[IDX_W-1:0];
            cmd.prev   = PTR_EMPTY;
            cmd.unlink = 1'b1;
            cmd.wr_tag = 1'b1;
            cmd.tag    = tcur_ff;
            grant      = 1'b1;
            grant_idx  = head[IDX_W-1:0];
         end
         S_WALK: begin
            rd_idx = cur_ff[IDX_W-1:0];
            if (rd_tag == tcur_ff) begin
               cmd.op     = OP_TAKE;
               cmd.idx    = cur_ff[IDX_W-1:0];
               cmd.prev   = prev_ff;
               cmd.unlink = 1'b1;
               grant      = 1'b1;
               grant_idx  = cur_ff[IDX_W-1:0];
            end else if (rd_link[IDX_W] || n_ff == LAST_IDX) begin
               state_in = S_HEAD;
            end else begin
               prev_in = cur_ff;
               cur_in  = rd_link;
               n_in    = n_ff + 1'b1;
            end
         end
         S_SCAN: begin
            rd_idx = scan_ff;
            if (rd_status == ST_ABSENT) begin
               cmd.op     = OP_TAKE;
               cmd.idx    = scan_ff;
               cmd.wr_tag = 1'b1;
               cmd.tag    = NO_TAG;
               live_in    = live_ff + 1'b1;
               grant      = 1'b1;
               grant_idx  = scan_ff;
            end else if (scan_ff == LAST_IDX) begin
               state_in = S_ROLL;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_ROLL: begin
            // hand back grants last first, retagged start+j (saturating at TAG_MAX) unless untagged
            if (i_ff == '0) begin
               succ_in   = 1'b0;
               status_in = RSP_EXHAUST;
               oidx_in   = '0;
               state_in  = S_RESP;
            end else begin
               cmd.op     = OP_IDLE;
               cmd.idx    = g_data;
               cmd.wr_tag = (start_ff != NO_TAG);
               cmd.tag    = roll_tag;
               i_in       = i_ff - 1'b1;
            end
         end
         S_DROP: begin
            rd_idx         = scan_ff;
            cmd.op         = OP_FREE;
            cmd.idx        = scan_ff;
            cmd.clear_head = (scan_ff == '0);
            if (rd_status == ST_IDLE && live_ff != '0) begin
               live_in = live_ff - 1'b1;
            end
            if (scan_ff == LAST_IDX) begin
               state_in = S_RESP;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               if (succ_ff && !rsp_last) begin
                  oidx_in = oidx_ff + 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (grant) begin
         i_in    = i_ff + 1'b1;
         tcur_in = tag_next;
         if (i_ff + 6'd1 == cnt_ff) begin
            succ_in   = 1'b1;
            status_in = RSP_OK;
            oidx_in   = '0;
            state_in  = S_RESP;
         end else begin
            state_in = S_TAKE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         live_ff  <= '0;
         limit_ff <= CNT_W'(MAX_GRANTS);
         succ_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         live_ff  <= live_in;
         succ_ff  <= succ_in;
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      cnt_ff    <= cnt_in;
      start_ff  <= start_in;
      tcur_ff   <= tcur_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      n_ff      <= n_in;
      scan_ff   <= scan_in;
      oidx_ff   <= oidx_in;
      status_ff <= status_in;
      if (grant) begin
         granted_ff[i_ff[IDX_W-1:0]] <= grant_idx;
      end
   end

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CNT_W'(MAX_ENTRIES))
      else $error("live count above pool size");

   a_grant_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && succ_ff) |-> ({1'b0, oidx_ff} < cnt_ff && i_ff == cnt_ff))
      else $error("response beat beyond granted handles");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROLL && i_ff == '0) |=> (state_ff == S_RESP && status_ff == RSP_EXHAUST))
      else $error("rollback did not end in exhaustion response");

endmodule
